[sv/sldm_pkg.sv]
// Shared definitions for the slew-limited differential mixer: register
// indexes, reset values, fixed field widths and the scaling-lane control bundle.
// No dependencies.
package sldm_pkg;

	// Fixed field widths
	localparam int STEP_BITS   = 15;
	localparam int LIMIT_BITS  = 16;
	localparam int OUT_BITS    = 18;
	localparam int CFG_IDX_BITS = 2;

	// Default width of the kept speed and turn values
	localparam int VALUE_WIDTH_DEF = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_SPEED_STEP   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TURN_STEP    = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_VELOCITY = 2'd2;

	// Reset values: 0.10 and 0.25 in Q3.12, limit off
	localparam logic [STEP_BITS-1:0]  SPEED_STEP_RST   = 15'd410;
	localparam logic [STEP_BITS-1:0]  TURN_STEP_RST    = 15'd1024;
	localparam logic [LIMIT_BITS-1:0] MAX_VELOCITY_RST = 16'd0;

	// Sequencer commands to one scaling lane
	typedef struct packed {
		logic load;
		logic mul;
		logic div_load;
		logic div;
	} lane_ctl_t;

endpackage

[sv/sldm_scale_lane.sv]
// One scaling lane: bit-serial shift-add multiply of a magnitude by the limit,
// then a restoring division of the product by the largest magnitude.
// Depends on sldm_pkg.
module sldm_scale_lane #(
	parameter int VALUE_WIDTH = sldm_pkg::VALUE_WIDTH_DEF
) (
	input  logic                             clk,
	input  sldm_pkg::lane_ctl_t              ctl,
	input  logic [VALUE_WIDTH:0]             mag,
	input  logic [sldm_pkg::LIMIT_BITS-1:0]  lim,
	input  logic [VALUE_WIDTH:0]             divisor,
	output logic [sldm_pkg::LIMIT_BITS-1:0]  quot
);

	localparam int LB = sldm_pkg::LIMIT_BITS;
	localparam int MW = VALUE_WIDTH + 1;
	localparam int PW = MW + LB;

	logic [PW-1:0] mcand_q;
	logic [PW-1:0] acc_q;
	logic [LB-1:0] shf_q;
	logic [MW-1:0] rem_q;
	logic [MW:0]   trial;
	logic [MW:0]   diff;
	logic          ge;

	// One quotient bit per cycle; the partial remainder always stays below the divisor
	assign trial = {rem_q, shf_q[LB-1]};
	assign diff  = trial - {1'b0, divisor};
	assign ge    = trial >= {1'b0, divisor};
	assign quot  = shf_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			acc_q   <= '0;
			mcand_q <= PW'(mag);
			shf_q   <= lim;
		end else if (ctl.mul) begin
			if (shf_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q <= mcand_q << 1;
			shf_q   <= shf_q >> 1;
		end else if (ctl.div_load) begin
			// product < 2^LB * divisor, so the upper part already sits below the divisor
			rem_q <= acc_q[PW-1:LB];
			shf_q <= acc_q[LB-1:0];
		end else if (ctl.div) begin
			rem_q <= ge ? diff[MW-1:0] : trial[MW-1:0];
			shf_q <= {shf_q[LB-2:0], ge};
		end
	end

endmodule

[sv/slew_limited_differential_mixer.sv]
// Top level of the slew-limited differential drive mixer: configuration
// registers, slew limiter, mixer, sequencer and two scaling lanes.
// Depends on sldm_pkg and sldm_scale_lane.
//
// Usage
//   Input channel (in_valid/in_ready) carries one request per control tick:
//   target_speed and target_turn, signed Q3.12. The kept speed and turn move
//   toward their targets by at most speed_step / turn_step, are mixed into
//   left = -(speed + turn) and right = speed - turn, and, when max_velocity is
//   non-zero and the larger magnitude exceeds it, both are scaled by
//   max_velocity / largest with truncation toward zero (was_scaled set).
//   Output channel (out_valid/out_ready) returns one request per input request.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
//   ready; index 0 speed_step, 1 turn_step, 2 max_velocity, others dropped.
//   From acceptance, a request passes through the mix and done states to out_valid
//   when no scaling is needed; when scaling, the 16-step serial multiply and the
//   16-step restoring division in each lane run in between. One request is in flight
//   at a time, so no new request is taken until the last one has left the done state.
//   Reset clears the kept speed and turn, loads steps of 0.10 and 0.25 and
//   disables the limit; no result is pending after reset.
//   Stall: a finished result waits in the output register while the next
//   request is accepted and worked on; that request holds in its last state
//   until the output register frees.
module slew_limited_differential_mixer #(
	parameter int VALUE_WIDTH = sldm_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [VALUE_WIDTH-1:0]         target_speed,
	input  logic signed [VALUE_WIDTH-1:0]         target_turn,
	// output channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [sldm_pkg::OUT_BITS-1:0]  left_velocity,
	output logic signed [sldm_pkg::OUT_BITS-1:0]  right_velocity,
	output logic                                  was_scaled,
	// configuration channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [sldm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [sldm_pkg::LIMIT_BITS-1:0]       cfg_data
);

	localparam int SB  = sldm_pkg::STEP_BITS;
	localparam int LB  = sldm_pkg::LIMIT_BITS;
	localparam int OB  = sldm_pkg::OUT_BITS;
	// difference of two kept values, wide enough to compare against a step
	localparam int DW  = ((VALUE_WIDTH + 1 > SB + 1) ? VALUE_WIDTH + 1 : SB + 1) + 1;
	// mixed command width and magnitude width
	localparam int XW  = VALUE_WIDTH + 2;
	localparam int MW  = VALUE_WIDTH + 1;
	// compare width for magnitude against limit
	localparam int CW  = ((MW > LB) ? MW : LB) + 1;
	localparam int CNTW = $clog2(LB);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MIX,
		S_MUL,
		S_DIVLD,
		S_DIV,
		S_DONE
	} state_t;

	state_t state_q;
	logic [CNTW-1:0] cnt_q;

	// configuration registers
	logic [SB-1:0] speed_step_q;
	logic [SB-1:0] turn_step_q;
	logic [LB-1:0] max_velocity_q;

	// kept state
	logic signed [VALUE_WIDTH-1:0] cur_speed_q;
	logic signed [VALUE_WIDTH-1:0] cur_turn_q;

	// mixed commands and scaling context
	logic signed [XW-1:0] left_q;
	logic signed [XW-1:0] right_q;
	logic [MW-1:0]        largest_q;
	logic                 scaled_q;

	// output register
	logic                 out_valid_q;
	logic signed [OB-1:0] left_out_q;
	logic signed [OB-1:0] right_out_q;
	logic                 was_scaled_q;

	logic accept;
	logic cnt_last;

	// slew limiter
	logic signed [DW-1:0]          spd_d, trn_d, spd_stp, trn_stp, spd_nx, trn_nx;
	logic signed [VALUE_WIDTH-1:0] next_speed, next_turn;

	// mixer
	logic signed [XW-1:0] left_w, right_w, left_abs, right_abs;
	logic [MW-1:0]        left_mag, right_mag, largest_w;
	logic                 scale_w;

	// lanes
	sldm_pkg::lane_ctl_t lane_ctl;
	logic [LB-1:0]       left_quot, right_quot;
	logic signed [OB-1:0] left_qx, right_qx, left_fin, right_fin;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cnt_last  = (cnt_q == CNTW'(LB - 1));

	assign out_valid      = out_valid_q;
	assign left_velocity  = left_out_q;
	assign right_velocity = right_out_q;
	assign was_scaled     = was_scaled_q;

	// Move each kept value toward its target by at most one step; land on it when near.
	always_comb begin
		spd_stp = $signed(DW'(speed_step_q));
		trn_stp = $signed(DW'(turn_step_q));
		spd_d   = DW'(target_speed) - DW'(cur_speed_q);
		trn_d   = DW'(target_turn) - DW'(cur_turn_q);

		if (spd_d > spd_stp) begin
			spd_nx = DW'(cur_speed_q) + spd_stp;
		end else if (spd_d < -spd_stp) begin
			spd_nx = DW'(cur_speed_q) - spd_stp;
		end else begin
			spd_nx = DW'(target_speed);
		end

		if (trn_d > trn_stp) begin
			trn_nx = DW'(cur_turn_q) + trn_stp;
		end else if (trn_d < -trn_stp) begin
			trn_nx = DW'(cur_turn_q) - trn_stp;
		end else begin
			trn_nx = DW'(target_turn);
		end

		next_speed = spd_nx[VALUE_WIDTH-1:0];
		next_turn  = trn_nx[VALUE_WIDTH-1:0];
	end

	// Mix the updated state; left is mirrored.
	always_comb begin
		left_w    = -(XW'(cur_speed_q) + XW'(cur_turn_q));
		right_w   = XW'(cur_speed_q) - XW'(cur_turn_q);
		left_abs  = left_w[XW-1] ? -left_w : left_w;
		right_abs = right_w[XW-1] ? -right_w : right_w;
		left_mag  = left_abs[MW-1:0];
		right_mag = right_abs[MW-1:0];
		largest_w = (right_mag > left_mag) ? right_mag : left_mag;
		// strictly above the limit; a zero limit switches scaling off
		scale_w   = (max_velocity_q != '0) && (CW'(largest_w) > CW'(max_velocity_q));
	end

	always_comb begin
		lane_ctl.load     = (state_q == S_MIX);
		lane_ctl.mul      = (state_q == S_MUL);
		lane_ctl.div_load = (state_q == S_DIVLD);
		lane_ctl.div      = (state_q == S_DIV);
	end

	sldm_scale_lane #(.VALUE_WIDTH(VALUE_WIDTH)) u_lane_left (
		.clk     (clk),
		.ctl     (lane_ctl),
		.mag     (left_mag),
		.lim     (max_velocity_q),
		.divisor (largest_q),
		.quot    (left_quot)
	);

	sldm_scale_lane #(.VALUE_WIDTH(VALUE_WIDTH)) u_lane_right (
		.clk     (clk),
		.ctl     (lane_ctl),
		.mag     (right_mag),
		.lim     (max_velocity_q),
		.divisor (largest_q),
		.quot    (right_quot)
	);

	// Quotients are magnitudes; put the sign back so the result truncates toward zero.
	always_comb begin
		left_qx   = OB'(left_quot);
		right_qx  = OB'(right_quot);
		left_fin  = scaled_q ? (left_q[XW-1] ? -left_qx : left_qx) : OB'(left_q);
		right_fin = scaled_q ? (right_q[XW-1] ? -right_qx : right_qx) : OB'(right_q);
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_step_q   <= sldm_pkg::SPEED_STEP_RST;
			turn_step_q    <= sldm_pkg::TURN_STEP_RST;
			max_velocity_q <= sldm_pkg::MAX_VELOCITY_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sldm_pkg::REG_SPEED_STEP:   speed_step_q   <= cfg_data[SB-1:0];
				sldm_pkg::REG_TURN_STEP:    turn_step_q    <= cfg_data[SB-1:0];
				sldm_pkg::REG_MAX_VELOCITY: max_velocity_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer, kept state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			cur_speed_q <= '0;
			cur_turn_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drop the result once taken; the final step loads its own
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cur_speed_q <= next_speed;
						cur_turn_q  <= next_turn;
						state_q     <= S_MIX;
					end
				end
				S_MIX: begin
					cnt_q   <= '0;
					state_q <= scale_w ? S_MUL : S_DONE;
				end
				S_MUL: begin
					if (cnt_last) begin
						cnt_q   <= '0;
						state_q <= S_DIVLD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DIVLD: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_last) begin
						cnt_q   <= '0;
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DONE: begin
					// hold here until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_MIX) begin
			left_q    <= left_w;
			right_q   <= right_w;
			largest_q <= largest_w;
			scaled_q  <= scale_w;
		end
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			left_out_q   <= left_fin;
			right_out_q  <= right_fin;
			was_scaled_q <= scaled_q;
		end
	end

endmodule

[sv/sldm_checker.sv]
// Port-level checks for the slew-limited differential mixer, bound to the top.
// Depends on sldm_pkg and slew_limited_differential_mixer.
module sldm_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [sldm_pkg::OUT_BITS-1:0] left_velocity,
	input logic signed [sldm_pkg::OUT_BITS-1:0] right_velocity,
	input logic                                 was_scaled
);

	// one request in flight: acceptance closes the input
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input still open after a request was accepted");

	// a result only appears from the final step, when the input is closed
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without a request being worked on");

	// scaled commands never exceed the 16-bit limit in magnitude
	a_scaled_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_scaled |->
		(left_velocity[17:16] == 2'b00 || left_velocity[17:16] == 2'b11) &&
		(right_velocity[17:16] == 2'b00 || right_velocity[17:16] == 2'b11))
		else $error("scaled command outside the limit range");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_velocity) &&
		$stable(right_velocity) && $stable(was_scaled))
		else $error("stalled result changed");

endmodule

bind slew_limited_differential_mixer sldm_checker u_sldm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.left_velocity  (left_velocity),
	.right_velocity (right_velocity),
	.was_scaled     (was_scaled)
);

[bench/tb_slew_limited_differential_mixer.sv]
// Self-checking bench for slew_limited_differential_mixer: directed and random ticks,
// register writes between phases, random idling on both channels.
// Depends on sldm_pkg and the mixer RTL.
`timescale 1ns / 1ps

module tb_slew_limited_differential_mixer;

	localparam int VW           = sldm_pkg::VALUE_WIDTH_DEF;
	localparam int DRAIN_CYCLES = 40;      // longer than the scaling path
	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_TICKS = 1150;
	localparam int PHASES       = 10;

	// One control tick and the motor command that it should produce
	typedef struct packed {
		logic signed [VW-1:0] speed;
		logic signed [VW-1:0] turn;
	} tick_t;

	typedef struct packed {
		logic signed [sldm_pkg::OUT_BITS-1:0] left;
		logic signed [sldm_pkg::OUT_BITS-1:0] right;
		logic                                 scaled;
	} motor_cmd_t;

	typedef struct packed {
		logic [sldm_pkg::CFG_IDX_BITS-1:0] idx;
		logic [sldm_pkg::LIMIT_BITS-1:0]   data;
	} reg_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                                 in_valid = 1'b0;
	logic                                 in_ready;
	logic signed [VW-1:0]                 target_speed = '0;
	logic signed [VW-1:0]                 target_turn = '0;
	logic                                 out_valid;
	logic                                 out_ready = 1'b0;
	logic signed [sldm_pkg::OUT_BITS-1:0] left_velocity;
	logic signed [sldm_pkg::OUT_BITS-1:0] right_velocity;
	logic                                 was_scaled;
	logic                                 cfg_valid = 1'b0;
	logic                                 cfg_ready;
	logic [sldm_pkg::CFG_IDX_BITS-1:0]    cfg_index = '0;
	logic [sldm_pkg::LIMIT_BITS-1:0]      cfg_data = '0;

	slew_limited_differential_mixer #(
		.VALUE_WIDTH(VW)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.target_speed  (target_speed),
		.target_turn   (target_turn),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.left_velocity (left_velocity),
		.right_velocity(right_velocity),
		.was_scaled    (was_scaled),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Requests waiting to be driven, and commands waiting to come back
	tick_t      pending_ticks[$];
	reg_write_t pending_writes[$];
	motor_cmd_t expected_cmds[$];

	// Predictor copy of the registers and of the kept speed and turn
	logic [sldm_pkg::STEP_BITS-1:0]  speed_step_q = sldm_pkg::SPEED_STEP_RST;
	logic [sldm_pkg::STEP_BITS-1:0]  turn_step_q = sldm_pkg::TURN_STEP_RST;
	logic [sldm_pkg::LIMIT_BITS-1:0] max_velocity_q = sldm_pkg::MAX_VELOCITY_RST;
	logic signed [VW-1:0]            kept_speed = '0;
	logic signed [VW-1:0]            kept_turn = '0;

	int  error_count = 0;
	int  cycle_count = 0;
	int  send_gap = 0;
	int  recv_gap = 0;
	bit  idling_on = 1'b1;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	// Move one kept value toward its goal by at most one step, landing on it when close
	function automatic logic signed [VW-1:0] slew_toward(logic signed [VW-1:0] now_v,
			logic signed [VW-1:0] goal, logic [sldm_pkg::STEP_BITS-1:0] step);
		longint diff;
		longint s;
		longint r;
		diff = longint'(goal) - longint'(now_v);
		s = longint'(step);
		if (diff > s)
			r = longint'(now_v) + s;
		else if (diff < -s)
			r = longint'(now_v) - s;
		else
			r = longint'(goal);
		return r[VW-1:0];
	endfunction

	// Advance the kept state by one tick and mix it into the motor command
	function automatic motor_cmd_t predict_motor_cmd(logic signed [VW-1:0] want_speed,
			logic signed [VW-1:0] want_turn);
		motor_cmd_t cmd;
		longint left;
		longint right;
		longint largest;
		longint lim;
		kept_speed = slew_toward(kept_speed, want_speed, speed_step_q);
		kept_turn = slew_toward(kept_turn, want_turn, turn_step_q);
		left = -(longint'(kept_speed) + longint'(kept_turn));
		right = longint'(kept_speed) - longint'(kept_turn);
		largest = (left < 0) ? -left : left;
		if (((right < 0) ? -right : right) > largest)
			largest = (right < 0) ? -right : right;
		lim = longint'(max_velocity_q);
		cmd.scaled = 1'b0;
		if (lim > 0 && largest > lim) begin
			// Signed division truncates toward zero, as the block does
			left = (left * lim) / largest;
			right = (right * lim) / largest;
			cmd.scaled = 1'b1;
		end
		cmd.left = left[sldm_pkg::OUT_BITS-1:0];
		cmd.right = right[sldm_pkg::OUT_BITS-1:0];
		return cmd;
	endfunction

	// Input driver: present the next tick, hold it until accepted, predict on acceptance
	always @(posedge clk or negedge arst_n) begin
		tick_t tick;
		if (!arst_n) begin
			in_valid <= 1'b0;
			target_speed <= '0;
			target_turn <= '0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready)
				expected_cmds.push_back(predict_motor_cmd(target_speed, target_turn));
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_ticks.size() != 0) begin
					tick = pending_ticks.pop_front();
					in_valid <= 1'b1;
					target_speed <= tick.speed;
					target_turn <= tick.turn;
					// Insert a short gap after this request now and then
					if (idling_on && $urandom_range(0, 3) == 0)
						send_gap = $urandom_range(1, 3);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Register write driver: the predictor takes each write as the block accepts it
	always @(posedge clk or negedge arst_n) begin
		reg_write_t wr;
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			cfg_index <= '0;
			cfg_data <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				// Drop bits above each register's width; other indexes are ignored
				case (cfg_index)
					sldm_pkg::REG_SPEED_STEP:
						speed_step_q = cfg_data[sldm_pkg::STEP_BITS-1:0];
					sldm_pkg::REG_TURN_STEP:
						turn_step_q = cfg_data[sldm_pkg::STEP_BITS-1:0];
					sldm_pkg::REG_MAX_VELOCITY:
						max_velocity_q = cfg_data;
					default: ;
				endcase
			end
			if (!cfg_valid || cfg_ready) begin
				if (pending_writes.size() != 0) begin
					wr = pending_writes.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= wr.idx;
					cfg_data <= wr.data;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: stall in bursts, check each accepted result against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		motor_cmd_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_cmds.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					want = expected_cmds.pop_front();
					if (left_velocity !== want.left)
						report_mismatch($sformatf("left_velocity got %0d, expected %0d",
							left_velocity, want.left));
					if (right_velocity !== want.right)
						report_mismatch($sformatf("right_velocity got %0d, expected %0d",
							right_velocity, want.right));
					if (was_scaled !== want.scaled)
						report_mismatch($sformatf("was_scaled got %0b, expected %0b",
							was_scaled, want.scaled));
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (idling_on && $urandom_range(0, 5) == 0)
					recv_gap = $urandom_range(1, 3);
			end
		end
	end

	// Watchdog: end the run if it hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic push_tick(int s, int t);
		tick_t tick;
		tick.speed = VW'(s);
		tick.turn = VW'(t);
		pending_ticks.push_back(tick);
	endtask

	// Hold until every request is sent and answered, then let the block settle
	task automatic drain();
		while (pending_ticks.size() != 0 || in_valid || expected_cmds.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write one register and hold until the write has been taken
	task automatic write_reg(logic [sldm_pkg::CFG_IDX_BITS-1:0] idx,
			logic [sldm_pkg::LIMIT_BITS-1:0] data);
		reg_write_t wr;
		wr.idx = idx;
		wr.data = data;
		pending_writes.push_back(wr);
		while (pending_writes.size() != 0 || cfg_valid)
			@(posedge clk);
		// let the last write land before any request can follow
		@(posedge clk);
	endtask

	function automatic logic signed [VW-1:0] pick_extreme();
		case ($urandom_range(0, 3))
			0: return {1'b0, {(VW-1){1'b1}}};
			1: return {1'b1, {(VW-1){1'b0}}};
			2: return '0;
			default: return '1;
		endcase
	endfunction

	function automatic logic [sldm_pkg::LIMIT_BITS-1:0] pick_reg_data();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return sldm_pkg::LIMIT_BITS'($urandom_range(1, 64));
			3: return sldm_pkg::LIMIT_BITS'($urandom_range(256, 4096));
			4: return sldm_pkg::LIMIT_BITS'($urandom_range(8192, 40000));
			default: return sldm_pkg::LIMIT_BITS'($urandom);
		endcase
	endfunction

	initial begin
		int per_phase;
		int hold;
		int sent;
		logic signed [VW-1:0] goal_speed;
		logic signed [VW-1:0] goal_turn;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset values: small steps, limit off
		push_tick(0, 0);
		push_tick(32767, -32768);
		push_tick(-32768, 32767);
		drain();

		// Full steps; bit 15 of a step write must be dropped, index 3 is ignored
		write_reg(sldm_pkg::REG_SPEED_STEP, 16'hFFFF);
		write_reg(sldm_pkg::REG_TURN_STEP, 16'hFFFF);
		write_reg(2'd3, 16'hFFFF);
		push_tick(32767, 32767);
		push_tick(-32768, -32768);
		push_tick(32767, -32768);
		push_tick(-32768, 32767);
		drain();

		// Largest limit: only the full negative corner exceeds it
		write_reg(sldm_pkg::REG_MAX_VELOCITY, 16'hFFFF);
		push_tick(-32768, -32768);
		push_tick(32767, 32767);
		drain();

		// Limit of 1.0: magnitude equal to it passes, above it scales with truncation
		write_reg(sldm_pkg::REG_MAX_VELOCITY, 16'd4096);
		push_tick(4096, 0);
		push_tick(0, -4096);
		push_tick(5000, -123);
		push_tick(-3001, 2000);
		push_tick(1, 0);
		drain();

		// Zero steps: nothing moves unless already on target
		write_reg(sldm_pkg::REG_SPEED_STEP, 16'd0);
		write_reg(sldm_pkg::REG_TURN_STEP, 16'd0);
		push_tick(20000, -20000);
		push_tick(1, 0);
		push_tick(1, 5);
		drain();

		// Unit steps with the limit switched off again
		write_reg(sldm_pkg::REG_SPEED_STEP, 16'd1);
		write_reg(sldm_pkg::REG_TURN_STEP, 16'd1);
		write_reg(sldm_pkg::REG_MAX_VELOCITY, 16'd0);
		push_tick(3, 0);
		push_tick(2, 1);
		drain();

		// Random phases: fresh register settings each time, targets held for runs
		// of ticks so the kept values both chase and land
		per_phase = RANDOM_TICKS / PHASES;
		for (int ph = 0; ph < PHASES; ph++) begin
			write_reg(sldm_pkg::REG_SPEED_STEP, pick_reg_data());
			write_reg(sldm_pkg::REG_TURN_STEP, pick_reg_data());
			write_reg(sldm_pkg::REG_MAX_VELOCITY, pick_reg_data());
			if ($urandom_range(0, 3) == 0)
				write_reg(2'd3, sldm_pkg::LIMIT_BITS'($urandom));
			// No idling in the closing phase
			idling_on = (ph != PHASES - 1);
			sent = 0;
			while (sent < per_phase) begin
				case ($urandom_range(0, 3))
					0: begin
						goal_speed = pick_extreme();
						goal_turn = pick_extreme();
					end
					1: begin
						goal_speed = VW'($urandom_range(0, 8191)) - VW'(4096);
						goal_turn = VW'($urandom_range(0, 8191)) - VW'(4096);
					end
					default: begin
						goal_speed = VW'($urandom);
						goal_turn = VW'($urandom);
					end
				endcase
				hold = $urandom_range(1, 24);
				for (int k = 0; k < hold && sent < per_phase; k++) begin
					// Now and then a lone stray tick breaks the run
					if ($urandom_range(0, 15) == 0)
						push_tick(int'($urandom), int'($urandom));
					else
						push_tick(goal_speed, goal_turn);
					sent++;
				end
			end
			drain();
		end

		if (expected_cmds.size() != 0)
			report_mismatch("commands still outstanding at the end");
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
